@@ rtl/stch_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package stch_pkg;

  localparam int unsigned DATA_W = 64;

  typedef logic [DATA_W-1:0] word_t;

  // operation codes
  localparam logic [2:0] OP_ADD      = 3'd0;
  localparam logic [2:0] OP_SET      = 3'd1;
  localparam logic [2:0] OP_MAX      = 3'd2;
  localparam logic [2:0] OP_RECORD   = 3'd3;
  localparam logic [2:0] OP_RD_CNT   = 3'd4;
  localparam logic [2:0] OP_RD_HIST  = 3'd5;

  // per-phase summary words
  localparam logic [1:0] FLD_COUNT = 2'd0;
  localparam logic [1:0] FLD_SUM   = 2'd1;
  localparam logic [1:0] FLD_MIN   = 2'd2;
  localparam logic [1:0] FLD_MAX   = 2'd3;

  // histogram words below this index are summary words, the rest are buckets
  localparam logic [6:0] HIST_BUCKET_BASE = 7'd4;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_IGNORED = 1'b1;

  typedef struct packed {
    word_t tmax;
    word_t tmin;
    word_t sum;
    word_t count;
  } phase_rec_t;

  typedef struct packed {
    logic [2:0] op;
    logic       ok;           // access is carried out
    logic       phase_field;  // op 5 reads a summary word, not a bucket
    logic [1:0] field_sel;
    word_t      operand;
  } req_t;

  function automatic word_t add_sat(input word_t a, input word_t b);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DATA_W] ? '1 : s[DATA_W-1:0];
  endfunction

  // index of the highest set bit, zero for zero
  function automatic logic [5:0] msb_index(input word_t v);
    logic [5:0] idx;
    idx = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (v[i]) idx = 6'(i);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

@@ rtl/stch_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module stch_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/stch_decode.sv @@
`timescale 1ns / 1ps
`default_nettype none

module stch_decode #(
  parameter int unsigned NUM_COUNTERS = 54,
  parameter int unsigned NUM_PHASES   = 16,
  parameter int unsigned NUM_BUCKETS  = 64,
  localparam int unsigned WDEPTH = NUM_COUNTERS + NUM_PHASES * NUM_BUCKETS,
  localparam int unsigned WAW    = $clog2(WDEPTH),
  localparam int unsigned PAW    = (NUM_PHASES > 1) ? $clog2(NUM_PHASES) : 1
) (
  input  wire logic                  enabled,
  input  wire logic [2:0]            operation,
  input  wire logic [5:0]            slot_index,
  input  wire logic [63:0]           operand_value,
  input  wire logic [6:0]            histogram_word,
  output stch_pkg::req_t             req,
  output logic       [WAW-1:0]       word_addr,
  output logic       [PAW-1:0]       phase_addr
);

  import stch_pkg::*;

  localparam logic [6:0] NC7      = 7'(NUM_COUNTERS);
  localparam logic [6:0] NP7      = 7'(NUM_PHASES);
  localparam logic [6:0] WORD_END = 7'(NUM_BUCKETS + 4);
  localparam logic [5:0] LAST_B   = 6'(NUM_BUCKETS - 1);

  logic             cnt_ok;
  logic             ph_ok;
  logic [5:0]       bucket_raw;
  logic [5:0]       bucket;
  logic [WAW-1:0]   row_base;
  logic [6:0]       word_off;

  assign cnt_ok     = {1'b0, slot_index} < NC7;
  assign ph_ok      = {1'b0, slot_index} < NP7;
  assign bucket_raw = msb_index(operand_value);
  assign bucket     = (bucket_raw > LAST_B) ? LAST_B : bucket_raw;
  assign row_base   = WAW'(NUM_COUNTERS) + WAW'(slot_index) * WAW'(NUM_BUCKETS);
  assign word_off   = histogram_word - HIST_BUCKET_BASE;

  always_comb begin
    req.op          = operation;
    req.ok          = 1'b0;
    req.phase_field = histogram_word < HIST_BUCKET_BASE;
    req.field_sel   = histogram_word[1:0];
    req.operand     = operand_value;
    word_addr       = '0;
    phase_addr      = '0;
    unique case (operation) inside
      OP_ADD, OP_SET, OP_MAX: begin
        req.ok = enabled && cnt_ok;
        if (cnt_ok) word_addr = WAW'(slot_index);
      end
      OP_RECORD: begin
        req.ok = enabled && ph_ok;
        if (ph_ok) begin
          word_addr  = row_base + WAW'(bucket);
          phase_addr = PAW'(slot_index);
        end
      end
      OP_RD_CNT: begin
        req.ok = cnt_ok;
        if (cnt_ok) word_addr = WAW'(slot_index);
      end
      OP_RD_HIST: begin
        req.ok = ph_ok && (histogram_word < WORD_END);
        if (req.ok) begin
          phase_addr = PAW'(slot_index);
          if (!req.phase_field) word_addr = row_base + WAW'(word_off);
        end
      end
      default: req.ok = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/stch_update.sv @@
`timescale 1ns / 1ps
`default_nettype none

module stch_update (
  input  wire stch_pkg::req_t     req,
  input  wire stch_pkg::word_t    word_rd,
  input  wire stch_pkg::phase_rec_t phase_rd,
  output logic                    word_we,
  output stch_pkg::word_t         word_wdata,
  output logic                    phase_we,
  output stch_pkg::phase_rec_t    phase_wdata,
  output stch_pkg::word_t         read_data,
  output logic                    access_status
);

  import stch_pkg::*;

  word_t field_val;

  always_comb begin
    case (req.field_sel)
      FLD_COUNT: field_val = phase_rd.count;
      FLD_SUM:   field_val = phase_rd.sum;
      FLD_MIN:   field_val = phase_rd.tmin;
      default:   field_val = phase_rd.tmax;
    endcase
  end

  always_comb begin
    word_we       = 1'b0;
    word_wdata    = word_rd;
    phase_we      = 1'b0;
    phase_wdata   = phase_rd;
    read_data     = '0;
    access_status = req.ok ? STATUS_DONE : STATUS_IGNORED;
    unique case (req.op)
      OP_ADD: begin
        word_we    = req.ok;
        word_wdata = add_sat(word_rd, req.operand);
      end
      OP_SET: begin
        word_we    = req.ok;
        word_wdata = req.operand;
      end
      OP_MAX: begin
        word_we    = req.ok;
        word_wdata = (req.operand > word_rd) ? req.operand : word_rd;
      end
      OP_RECORD: begin
        word_we           = req.ok;
        word_wdata        = add_sat(word_rd, 64'd1);
        phase_we          = req.ok;
        phase_wdata.count = add_sat(phase_rd.count, 64'd1);
        phase_wdata.sum   = add_sat(phase_rd.sum, req.operand);
        // first sample always sets the minimum
        phase_wdata.tmin  = ((phase_rd.count == '0) || (req.operand < phase_rd.tmin)) ?
                            req.operand : phase_rd.tmin;
        phase_wdata.tmax  = (req.operand > phase_rd.tmax) ? req.operand : phase_rd.tmax;
      end
      OP_RD_CNT: begin
        if (req.ok) read_data = word_rd;
      end
      OP_RD_HIST: begin
        if (req.ok) read_data = req.phase_field ? field_val : word_rd;
      end
      default: begin
        word_we = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/stats_counter_latency_histogram_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// result: the output register is loaded at write back, which follows its input transfer
// flow: the transfer reads both memories, write back follows in the EXEC state, and no new
//   transfer is taken before that write back, which waits while an earlier result still
//   sits in the output register
// reset: rst clears control state, then a sweep over NUM_COUNTERS + NUM_PHASES*NUM_BUCKETS
//   words (1078 by default) zeroes both memories; no input transfer is taken until it ends

module stats_counter_latency_histogram_top #(
  parameter int unsigned NUM_COUNTERS = 54,
  parameter int unsigned NUM_PHASES   = 16,
  parameter int unsigned NUM_BUCKETS  = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_enable,
  input  wire logic        cfg_write_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  operation,
  input  wire logic [5:0]  slot_index,
  input  wire logic [63:0] operand_value,
  input  wire logic [6:0]  histogram_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [63:0] read_data,
  output logic             access_status
);

  import stch_pkg::*;

  // word memory: event counters first, then one row of buckets per phase
  localparam int unsigned WDEPTH = NUM_COUNTERS + NUM_PHASES * NUM_BUCKETS;
  localparam int unsigned WAW    = $clog2(WDEPTH);
  localparam int unsigned PAW    = (NUM_PHASES > 1) ? $clog2(NUM_PHASES) : 1;
  localparam int unsigned PREC_W = $bits(phase_rec_t);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0]     state;
  logic [1:0]     state_next;
  logic [WAW-1:0] clr_addr;
  logic           stats_enabled;

  req_t           dec_req;
  logic [WAW-1:0] dec_waddr;
  logic [PAW-1:0] dec_paddr;

  req_t           req;       // item at work
  logic [WAW-1:0] req_waddr;
  logic [PAW-1:0] req_paddr;

  logic           in_xfer;
  logic           exec_fire;
  logic           clr_last;

  word_t          word_rd;
  phase_rec_t     phase_rd;
  logic           upd_word_we;
  word_t          upd_word_wdata;
  logic           upd_phase_we;
  phase_rec_t     upd_phase_wdata;
  word_t          upd_read_data;
  logic           upd_status;

  // memory write ports, shared between the clearing sweep and write back
  logic           word_we;
  logic [WAW-1:0] word_waddr;
  word_t          word_wdata;
  logic           phase_we;
  logic [PAW-1:0] phase_waddr;
  phase_rec_t     phase_wdata;

  assign in_ready  = (state == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  // write back waits while an earlier result still sits in the output register
  assign exec_fire = (state == ST_EXEC) && (!out_valid || out_ready);
  assign clr_last  = (clr_addr == WAW'(WDEPTH - 1));

  // enable register: write it only while no item is at work; the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      stats_enabled <= 1'b0;
    end else if (cfg_write_enable) begin
      stats_enabled <= cfg_write_data;
    end
  end

  stch_decode #(
    .NUM_COUNTERS (NUM_COUNTERS),
    .NUM_PHASES   (NUM_PHASES),
    .NUM_BUCKETS  (NUM_BUCKETS)
  ) u_decode (
    .enabled        (stats_enabled),
    .operation      (operation),
    .slot_index     (slot_index),
    .operand_value  (operand_value),
    .histogram_word (histogram_word),
    .req            (dec_req),
    .word_addr      (dec_waddr),
    .phase_addr     (dec_paddr)
  );

  // state machine: clearing sweep, then alternate transfer and write back
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_last) state_next = ST_IDLE;
      ST_IDLE:  if (in_xfer) state_next = ST_EXEC;
      ST_EXEC:  if (exec_fire) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR && !clr_last) clr_addr <= clr_addr + 1'b1;
    end
  end

  // item registers, loaded on the input transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req       <= dec_req;
      req_waddr <= dec_waddr;
      req_paddr <= dec_paddr;
    end
  end

  // both memories are read at the transfer and hold their read data until write back
  stch_ram #(
    .WIDTH (DATA_W),
    .DEPTH (WDEPTH)
  ) u_word_ram (
    .clk   (clk),
    .we    (word_we),
    .waddr (word_waddr),
    .wdata (word_wdata),
    .re    (in_xfer),
    .raddr (dec_waddr),
    .rdata (word_rd)
  );

  stch_ram #(
    .WIDTH (PREC_W),
    .DEPTH (NUM_PHASES)
  ) u_phase_ram (
    .clk   (clk),
    .we    (phase_we),
    .waddr (phase_waddr),
    .wdata (phase_wdata),
    .re    (in_xfer),
    .raddr (dec_paddr),
    .rdata (phase_rd)
  );

  stch_update u_update (
    .req           (req),
    .word_rd       (word_rd),
    .phase_rd      (phase_rd),
    .word_we       (upd_word_we),
    .word_wdata    (upd_word_wdata),
    .phase_we      (upd_phase_we),
    .phase_wdata   (upd_phase_wdata),
    .read_data     (upd_read_data),
    .access_status (upd_status)
  );

  always_comb begin
    if (state == ST_CLEAR) begin
      word_we     = 1'b1;
      word_waddr  = clr_addr;
      word_wdata  = '0;
      phase_we    = (clr_addr < WAW'(NUM_PHASES));
      phase_waddr = clr_addr[PAW-1:0];
      phase_wdata = '0;
    end else begin
      word_we     = exec_fire && upd_word_we;
      word_waddr  = req_waddr;
      word_wdata  = upd_word_wdata;
      phase_we    = exec_fire && upd_phase_we;
      phase_waddr = req_paddr;
      phase_wdata = upd_phase_wdata;
    end
  end

  // output register: one result per item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      read_data     <= upd_read_data;
      access_status <= upd_status;
    end
  end

`ifndef SYNTHESIS
  // every transfer is followed by the EXEC state, where its write back happens
  a_xfer_to_exec: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == ST_EXEC))
    else $error("input transfer not followed by write back");

  // a new result only comes from a write back
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(exec_fire))
    else $error("result appeared without write back");

  // memories change only during the sweep or at write back
  a_write_window: assert property (@(posedge clk) disable iff (rst)
    (word_we || phase_we) |-> (state == ST_CLEAR || exec_fire))
    else $error("memory written outside sweep or write back");

  // an ignored access leaves both memories untouched
  a_ignored_no_write: assert property (@(posedge clk) disable iff (rst)
    (exec_fire && !req.ok) |-> (!word_we && !phase_we))
    else $error("ignored access wrote a memory");

  // a waiting result is not overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !exec_fire)
    else $error("result overwritten before its transfer");
`endif

endmodule

`default_nettype wire
